[rtl/slmp_pkg.sv]
// ----------------------------------------------------------------------------
// slmp_pkg
// Types and constants shared by the shortcut-list message parser.
// ----------------------------------------------------------------------------
package slmp_pkg;

	localparam int MAX_ENTRIES  = 8;
	localparam int MAX_NAME     = 16;
	localparam int MIN_MSG_LEN  = 3;
	localparam int ENTRY_HDR    = 3;
	localparam int MAX_MSG_LEN  = MIN_MSG_LEN + MAX_ENTRIES * (ENTRY_HDR + MAX_NAME);
	localparam int POS_MAX      = 1023;
	localparam logic [7:0] TYPE_CODE    = 8'h00;
	localparam logic [7:0] VERSION_CODE = 8'h01;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_TYPE    = 3'd0,
		PH_VERSION = 3'd1,
		PH_COUNT   = 3'd2,
		PH_ID      = 3'd3,
		PH_NAMELEN = 3'd4,
		PH_FLAGS   = 3'd5,
		PH_NAME    = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_COMMIT = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	// results caused by one input byte, in emission order: char, entry, end
	typedef struct packed {
		logic       has_char;
		logic       has_entry;
		logic       has_end;
		logic       end_reject;
		logic [2:0] slot;
		logic [3:0] char_index;
		logic [7:0] char_value;
		logic [7:0] shortcut_id;
		logic [4:0] name_length;
		logic       close_on_trigger;
		logic [3:0] entries_parsed;
	} bundle_t;

endpackage

[rtl/shortcut_list_message_parser_top.sv]
// ----------------------------------------------------------------------------
// shortcut_list_message_parser_top
// Shortcut-list message parser: one message byte in, name characters,
// completed entries and a commit or reject out.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low first)                    tuser        tlast
// s_axis   in   data_byte[7:0] message_length[17:8]         -            final_byte
// m_axis   out  slot, shortcut_id, name_length,             result_kind  last_in_run
//               close_on_trigger, char_index, char_value,
//               entries_parsed
//
// One byte is taken per cycle while the bundle queue has room.
// A byte yields up to three results; the output register sends one per cycle unless m_axis stalls.
// A byte's results pass through the bundle queue, the current-bundle register and the output register.
// Output stalls fill the four-entry queue, then hold s_axis_tready low.
// Asynchronous reset returns the parser to the header type phase.
// ----------------------------------------------------------------------------
module shortcut_list_message_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_byte[7:0], message_length[17:8]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // slot[2:0], shortcut_id[10:3], name_length[15:11],
	                                   // close_on_trigger[16], char_index[20:17],
	                                   // char_value[28:21], entries_parsed[32:29]
	output logic [1:0]  m_axis_tuser,  // result_kind[1:0]
	output logic        m_axis_tlast
);
	import slmp_pkg::*;

	logic    push;
	bundle_t push_bundle;
	logic    full;
	logic    pop;
	logic    empty;
	bundle_t head;

	slmp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.data_byte      (s_axis_tdata[7:0]),
		.message_length (s_axis_tdata[17:8]),
		.final_byte     (s_axis_tlast),
		.queue_full     (full),
		.push           (push),
		.push_bundle    (push_bundle)
	);

	slmp_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.full        (full),
		.pop         (pop),
		.empty       (empty),
		.head        (head)
	);

	slmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[rtl/slmp_front.sv]
// ----------------------------------------------------------------------------
// slmp_front
// Byte parser: tracks the message layout and builds the result bundle per byte.
// ----------------------------------------------------------------------------
module slmp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic [9:0]        message_length,
	input  logic              final_byte,
	input  logic              queue_full,
	output logic              push,
	output slmp_pkg::bundle_t push_bundle
);
	import slmp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [9:0] pos_q, pos_d;
	logic [3:0] count_q, count_d;
	logic [3:0] ent_q, ent_d;
	logic [7:0] id_q, id_d;
	logic [4:0] nlen_q, nlen_d;
	logic [4:0] npos_q, npos_d;
	logic       close_q, close_d;
	logic       rej_q, rej_d;
	logic       stop_q, stop_d;
	logic       accept;
	logic       active;
	logic       complete;
	logic [4:0] nlen_clamp;
	logic [3:0] count_clamp;
	logic [10:0] hdr_end;
	logic [10:0] name_end;
	bundle_t    b;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign nlen_clamp  = (data_byte < 8'(MAX_NAME)) ? data_byte[4:0] : 5'(MAX_NAME);
	assign count_clamp = (data_byte < 8'(MAX_ENTRIES)) ? data_byte[3:0] : 4'(MAX_ENTRIES);
	assign hdr_end     = {1'b0, pos_q} + 11'(ENTRY_HDR);
	assign name_end    = {1'b0, pos_q} + 11'd1 + {6'd0, nlen_q};

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		count_d  = count_q;
		ent_d    = ent_q;
		id_d     = id_q;
		nlen_d   = nlen_q;
		npos_d   = npos_q;
		close_d  = close_q;
		rej_d    = rej_q;
		stop_d   = stop_q;
		complete = 1'b0;
		b        = '0;
		b.slot   = ent_q[2:0];

		if (message_length < 10'(MIN_MSG_LEN) || message_length > 10'(MAX_MSG_LEN)) begin
			rej_d = 1'b1;
		end
		active = !rej_d && !stop_q && (pos_q < message_length);

		if (active) begin
			case (phase_q)
				PH_TYPE: begin
					if (data_byte != TYPE_CODE) rej_d = 1'b1;
					phase_d = PH_VERSION;
				end
				PH_VERSION: begin
					if (data_byte != VERSION_CODE) rej_d = 1'b1;
					phase_d = PH_COUNT;
				end
				PH_COUNT: begin
					count_d = count_clamp;
					ent_d   = '0;
					if (count_clamp == '0) stop_d = 1'b1;
					else phase_d = PH_ID;
				end
				PH_ID: begin
					if (hdr_end > {1'b0, message_length}) begin
						stop_d = 1'b1;
					end else begin
						id_d    = data_byte;
						phase_d = PH_NAMELEN;
					end
				end
				PH_NAMELEN: begin
					nlen_d  = nlen_clamp;
					phase_d = PH_FLAGS;
				end
				PH_FLAGS: begin
					close_d = data_byte[0];
					if (name_end > {1'b0, message_length}) begin
						stop_d = 1'b1;
					end else if (nlen_q == '0) begin
						complete = 1'b1;
					end else begin
						npos_d  = '0;
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					b.has_char   = 1'b1;
					b.char_index = npos_q[3:0];
					b.char_value = data_byte;
					npos_d       = npos_q + 5'd1;
					if (npos_d >= nlen_q) complete = 1'b1;
				end
				default: begin
					stop_d = 1'b1;
				end
			endcase
		end

		if (complete) begin
			b.has_entry        = 1'b1;
			b.shortcut_id      = id_q;
			b.name_length      = nlen_q;
			b.close_on_trigger = close_d;
			ent_d              = ent_q + 4'd1;
			if (ent_d >= count_d) stop_d = 1'b1;
			else phase_d = PH_ID;
		end

		if (pos_q != 10'(POS_MAX)) pos_d = pos_q + 10'd1;

		if (final_byte) begin
			b.has_end        = 1'b1;
			b.end_reject     = rej_d;
			b.entries_parsed = rej_d ? 4'd0 : ent_d;
			phase_d = PH_TYPE;
			pos_d   = '0;
			count_d = '0;
			ent_d   = '0;
			id_d    = '0;
			nlen_d  = '0;
			npos_d  = '0;
			close_d = 1'b0;
			rej_d   = 1'b0;
			stop_d  = 1'b0;
		end
	end

	assign push        = accept && (b.has_char || b.has_entry || b.has_end);
	assign push_bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			pos_q   <= '0;
			count_q <= '0;
			ent_q   <= '0;
			id_q    <= '0;
			nlen_q  <= '0;
			npos_q  <= '0;
			close_q <= 1'b0;
			rej_q   <= 1'b0;
			stop_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			ent_q   <= ent_d;
			id_q    <= id_d;
			nlen_q  <= nlen_d;
			npos_q  <= npos_d;
			close_q <= close_d;
			rej_q   <= rej_d;
			stop_q  <= stop_d;
		end
	end

endmodule

[rtl/slmp_queue.sv]
// ----------------------------------------------------------------------------
// slmp_queue
// Short FIFO of result bundles between the parser and the emitter.
// ----------------------------------------------------------------------------
module slmp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slmp_pkg::bundle_t push_bundle,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output slmp_pkg::bundle_t head
);
	import slmp_pkg::*;

	bundle_t           slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

[rtl/slmp_back.sv]
// ----------------------------------------------------------------------------
// slmp_back
// Result emitter: splits each bundle into result transfers behind an
// output register.
// ----------------------------------------------------------------------------
module slmp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  slmp_pkg::bundle_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [39:0]       out_data,
	output logic              out_last
);
	import slmp_pkg::*;

	bundle_t     cur_q;
	logic        pend_char_q, pend_entry_q, pend_end_q;
	logic        valid_q;
	kind_t       kind_q;
	logic [32:0] data_q;
	logic        last_q;

	logic        cur_any;
	logic        load;
	logic        sel_last;
	kind_t       sel_kind;
	logic [32:0] sel_data;

	assign cur_any = pend_char_q || pend_entry_q || pend_end_q;
	assign load    = cur_any && (!valid_q || out_ready);
	assign pop     = !empty && (!cur_any || (load && sel_last));

	always_comb begin
		sel_data = '0;
		if (pend_char_q) begin
			sel_kind       = KIND_CHAR;
			sel_last       = !(pend_entry_q || pend_end_q);
			sel_data[2:0]   = cur_q.slot;
			sel_data[20:17] = cur_q.char_index;
			sel_data[28:21] = cur_q.char_value;
		end else if (pend_entry_q) begin
			sel_kind       = KIND_ENTRY;
			sel_last       = !pend_end_q;
			sel_data[2:0]   = cur_q.slot;
			sel_data[10:3]  = cur_q.shortcut_id;
			sel_data[15:11] = cur_q.name_length;
			sel_data[16]    = cur_q.close_on_trigger;
		end else begin
			sel_kind       = cur_q.end_reject ? KIND_REJECT : KIND_COMMIT;
			sel_last       = 1'b1;
			sel_data[32:29] = cur_q.entries_parsed;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (load) begin
			kind_q <= sel_kind;
			data_q <= sel_data;
			last_q <= sel_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_char_q  <= 1'b0;
			pend_entry_q <= 1'b0;
			pend_end_q   <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				pend_char_q  <= head.has_char;
				pend_entry_q <= head.has_entry;
				pend_end_q   <= head.has_end;
			end else if (load) begin
				if (pend_char_q) pend_char_q <= 1'b0;
				else if (pend_entry_q) pend_entry_q <= 1'b0;
				else pend_end_q <= 1'b0;
			end
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = {7'd0, data_q};
	assign out_last  = last_q;

endmodule
